[hw/rtl/aes128_cfb8_encrypt_defines.svh]
// Assertion macros for the CFB8 encryptor
`ifndef AES128_CFB8_ENCRYPT_DEFINES_SVH
`define AES128_CFB8_ENCRYPT_DEFINES_SVH

// Implication checked on every rising edge outside reset
`define ACE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define ACE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/ace_pkg.sv]
// Package: AES tables, helper functions and command types
`timescale 1ns / 1ps
package ace_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned BlkW = 128;
    localparam int unsigned RoundsN = 10;
    localparam int unsigned RndW = 4;

    localparam logic [1:0] CfgKeyLow = 2'd0;
    localparam logic [1:0] CfgKeyHigh = 2'd1;
    localparam logic [1:0] CfgIvLow = 2'd2;
    localparam logic [1:0] CfgIvHigh = 2'd3;

    typedef struct packed {
        logic key_start;  // begin key expansion
        logic key_step;   // compute next round key
        logic load_blk;   // start a block (start mark / shift reg selected)
        logic round;      // apply one AES round
        logic finish;     // xor byte, shift feedback, present result
    } t_cmd;

    typedef struct packed {
        logic [RndW-1:0] round_num;
    } t_sts;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] rcon(input logic [RndW-1:0] r);
        logic [7:0] v;
        case (r)
            4'd1: v = 8'h01;
            4'd2: v = 8'h02;
            4'd3: v = 8'h04;
            4'd4: v = 8'h08;
            4'd5: v = 8'h10;
            4'd6: v = 8'h20;
            4'd7: v = 8'h40;
            4'd8: v = 8'h80;
            4'd9: v = 8'h1b;
            4'd10: v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

[hw/rtl/ace_ctrl.sv]
// Controller: sequences key expansion, rounds and result handoff
`timescale 1ns / 1ps
`include "aes128_cfb8_encrypt_defines.svh"
module ace_ctrl
    import ace_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_key_wr,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [1:0] {S_KEY, S_IDLE, S_RUN} t_state;

    t_state r_state;
    logic   r_key_pend;
    logic   r_out_valid;
    logic   w_take;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || r_key_pend || i_key_wr;
    assign w_take = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd = '0;
        o_cmd.key_start = (r_state == S_IDLE) && r_key_pend && !i_key_wr;
        o_cmd.key_step = (r_state == S_KEY);
        o_cmd.load_blk = w_take;
        o_cmd.round = (r_state == S_RUN) && (i_sts.round_num != RndW'(RoundsN + 1));
        o_cmd.finish = (r_state == S_RUN) && (i_sts.round_num == RndW'(RoundsN + 1))
                       && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_key_pend <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_key_wr) r_key_pend <= 1'b1;
            else if (o_cmd.key_start) r_key_pend <= 1'b0;
            if (o_cmd.finish) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_cmd.key_start) r_state <= S_KEY;
                    else if (w_take) r_state <= S_RUN;
                end
                S_KEY: begin
                    // last step produces round key 10
                    if (i_sts.round_num == RndW'(RoundsN - 1)) r_state <= S_IDLE;
                end
                S_RUN: begin
                    if (o_cmd.finish) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ACE_ASSERT_IMP(a_no_take_busy, i_clk, i_rst_n, r_state != S_IDLE, !w_take)
    `ACE_ASSERT_NXT(a_finish_valid, i_clk, i_rst_n, o_cmd.finish, r_out_valid)
    `ACE_ASSERT_IMP(a_one_cmd, i_clk, i_rst_n, 1'b1,
        $onehot0({o_cmd.key_start, o_cmd.key_step, o_cmd.load_blk, o_cmd.round}))
endmodule

[hw/rtl/ace_dp.sv]
// Datapath: config, round keys, AES state, feedback register
`timescale 1ns / 1ps
module ace_dp
    import ace_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic [7:0]  i_plain_byte,
    input  logic        i_start_message,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic [7:0]  o_cipher_byte
);
    logic [BlkW-1:0] r_key, r_iv, r_fb, r_st;
    logic [BlkW-1:0] r_rk [RoundsN+1];
    logic [BlkW-1:0] r_kexp;
    logic [RndW-1:0] r_rnd;
    logic [7:0]      r_pt, r_ct;
    logic [BlkW-1:0] n_kexp, n_st, w_sb, w_mc, w_blk;
    logic [31:0]     w_t;

    // next round key from the running one
    always_comb begin
        w_t = {sbox(r_kexp[103:96]), sbox(r_kexp[127:120]), sbox(r_kexp[119:112]),
               sbox(r_kexp[111:104]) ^ rcon(r_rnd + 4'd1)};
        n_kexp[31:0] = r_kexp[31:0] ^ w_t;
        n_kexp[63:32] = r_kexp[63:32] ^ n_kexp[31:0];
        n_kexp[95:64] = r_kexp[95:64] ^ n_kexp[63:32];
        n_kexp[127:96] = r_kexp[127:96] ^ n_kexp[95:64];
    end

    // one round: SubBytes+ShiftRows, MixColumns unless last, AddRoundKey
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                w_sb[8*(k+4*c) +: 8] = sbox(r_st[8*(k+4*((c+k)%4)) +: 8]);
            end
        end
        for (int c = 0; c < 4; c++) begin
            logic [7:0] a0, a1, a2, a3, al;
            a0 = w_sb[32*c +: 8]; a1 = w_sb[32*c+8 +: 8];
            a2 = w_sb[32*c+16 +: 8]; a3 = w_sb[32*c+24 +: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            w_mc[32*c +: 8] = a0 ^ al ^ xtime(a0 ^ a1);
            w_mc[32*c+8 +: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            w_mc[32*c+16 +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            w_mc[32*c+24 +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        n_st = ((r_rnd == RndW'(RoundsN)) ? w_sb : w_mc) ^ r_rk[r_rnd];
        w_blk = i_start_message ? r_iv : r_fb;
    end

    assign o_sts.round_num = r_rnd;
    assign o_cipher_byte = r_ct;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
            r_iv <= '0;
            r_fb <= '0;
            r_rnd <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CfgKeyLow: r_key[63:0] <= i_cfg_data;
                    CfgKeyHigh: r_key[127:64] <= i_cfg_data;
                    CfgIvLow: r_iv[63:0] <= i_cfg_data;
                    CfgIvHigh: r_iv[127:64] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.key_start) begin
                r_kexp <= r_key;
                r_rk[0] <= r_key;
                r_rnd <= '0;
            end else if (i_cmd.key_step) begin
                r_kexp <= n_kexp;
                r_rk[r_rnd + 4'd1] <= n_kexp;
                r_rnd <= (r_rnd == RndW'(RoundsN - 1)) ? '0 : r_rnd + 4'd1;
            end else if (i_cmd.load_blk) begin
                r_st <= w_blk ^ r_rk[0];
                r_fb <= w_blk;
                r_pt <= i_plain_byte;
                r_rnd <= 4'd1;
            end else if (i_cmd.round) begin
                r_st <= n_st;
                r_rnd <= r_rnd + 4'd1;
            end else if (i_cmd.finish) begin
                r_ct <= r_pt ^ r_st[7:0];
                r_fb <= {r_pt ^ r_st[7:0], r_fb[127:8]};
                r_rnd <= '0;
            end
        end
    end
endmodule

[hw/rtl/aes128_cfb8_encrypt.sv]
// Top level: AES-128 CFB8 byte encryptor
`timescale 1ns / 1ps
// One plaintext byte per item in, one ciphertext byte per item out. Each item
// runs a full AES-128 encryption of the 128-bit feedback register through one
// shared round unit: the block is loaded at the accepting edge, the AES rounds
// follow, then a result step registers the ciphertext byte. The next item is
// accepted in the cycle after the result is registered, unless a key write or
// key expansion is pending, so items never overlap. A stalled output holds the
// result step back. After reset and after any key register write the round
// keys are re-expanded (a start step, then the key steps), during which no item
// is accepted. start_message reloads the feedback register from the IV before
// the byte. Config index: 0 key_low, 1 key_high, 2 iv_low, 3 iv_high.
module aes128_cfb8_encrypt
    import ace_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_plain_byte,
    input  logic        i_start_message,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_cipher_byte
);
    t_cmd w_cmd;
    t_sts w_sts;
    logic w_key_wr;

    // key writes trigger a new expansion
    assign w_key_wr = i_cfg_we && (i_cfg_idx == CfgKeyLow || i_cfg_idx == CfgKeyHigh);

    ace_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_key_wr(w_key_wr),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_sts(w_sts), .o_cmd(w_cmd)
    );

    ace_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_plain_byte(i_plain_byte), .i_start_message(i_start_message),
        .i_cmd(w_cmd), .o_sts(w_sts), .o_cipher_byte(o_cipher_byte)
    );
endmodule
